>>> design/fpa_pkg.sv
// Shared types and constants for the fit-policy partition allocator.
package fpa_pkg;

  localparam int SLOT_FIELD_W = 4;
  localparam int AMOUNT_W     = 16;
  localparam int MODE_W       = 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Placement policies; any other code acts as first fit.
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  // Verdict of the fit unit on the slot under scan.
  typedef struct packed {
    logic take;
    logic stop;
  } fit_dec_t;

  typedef struct packed {
    logic                    granted;
    logic [SLOT_FIELD_W-1:0] chosen_slot;
    logic [AMOUNT_W-1:0]     remaining;
  } res_t;

endpackage

>>> design/fpa_if.sv
// Handshake channel interfaces: request, response and policy configuration.
interface fpa_req_if;
  import fpa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [SLOT_FIELD_W-1:0] slot_index;
  logic [AMOUNT_W-1:0]     amount;
  modport source (output valid, output opcode, output slot_index, output amount, input ready);
  modport sink   (input valid, input opcode, input slot_index, input amount, output ready);
endinterface

interface fpa_rsp_if;
  import fpa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    granted;
  logic [SLOT_FIELD_W-1:0] chosen_slot;
  logic [AMOUNT_W-1:0]     remaining;
  modport source (output valid, output granted, output chosen_slot, output remaining,
                  input ready);
  modport sink   (input valid, input granted, input chosen_slot, input remaining,
                  output ready);
endinterface

interface fpa_cfg_if;
  import fpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] fit_mode;
  modport source (output valid, output fit_mode, input ready);
  modport sink   (input valid, input fit_mode, output ready);
endinterface

>>> design/fit_policy_partition_allocator.sv
// Load item: taken while idle, no response; the block stays ready for the next item.
// Allocate item: scans one partition per cycle through one compare unit, then a commit
// state that writes the response into the output register (first fit may stop the scan
// early; a held output stalls the commit). No new item is taken until the commit is done.
// Reset clears the loaded flags, the policy (first fit) and the output valid.
module fit_policy_partition_allocator #(
  parameter int NUM_SLOTS = 16,
  parameter int SIZE_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  fpa_req_if.sink  req,
  fpa_rsp_if.source rsp,
  fpa_cfg_if.sink  cfg
);
  import fpa_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [MODE_W-1:0] fit_mode;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              rsp_valid;
  res_t              rsp_data;

  fpa_alloc_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .SIZE_BITS (SIZE_BITS),
    .SLOT_W    (SLOT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_opcode (req.opcode),
    .in_slot   (req.slot_index),
    .in_amount (req.amount),
    .fit_mode  (fit_mode),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign cfg.ready = 1'b1;
  assign res_ready = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        fit_mode <= cfg.fit_mode;
      end
      if (res_valid && res_ready) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (res_valid && res_ready) begin
      rsp_data <= res;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.granted     = rsp_data.granted;
  assign rsp.chosen_slot = rsp_data.chosen_slot;
  assign rsp.remaining   = rsp_data.remaining;

`ifndef SYNTH
  a_refusal_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.granted |-> (rsp.chosen_slot == '0) && (rsp.remaining == '0))
    else $error("refused response carries nonzero slot or remainder");

  a_busy_after_alloc: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && (req.opcode == OP_ALLOC) |=> !req.ready)
    else $error("request taken during an allocate scan");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.granted |-> int'(rsp.chosen_slot) < NUM_SLOTS)
    else $error("granted slot beyond partition count");
`endif

endmodule

>>> design/fpa_cap_mem.sv
// Free-capacity memory: one write port, one read port with registered data.
module fpa_cap_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/fpa_fit_unit.sv
// Shared compare unit: decides whether the scanned slot replaces the current pick.
module fpa_fit_unit #(
  parameter int SIZE_BITS = 16
) (
  input  logic [fpa_pkg::MODE_W-1:0] mode,
  input  logic [SIZE_BITS-1:0]       cap,
  input  logic [SIZE_BITS-1:0]       amt,
  input  logic [SIZE_BITS-1:0]       best,
  input  logic                       loaded,
  input  logic                       found,
  output fpa_pkg::fit_dec_t          dec
);
  import fpa_pkg::*;

  logic fits;
  logic better;

  always_comb begin
    fits   = loaded && (cap >= amt);
    better = ((mode == MODE_BEST) && (cap < best)) ||
             ((mode == MODE_WORST) && (cap > best));
    dec.take = fits && (!found || better);
    // first fit ends the scan at its first hit
    dec.stop = fits && !found && (mode != MODE_BEST) && (mode != MODE_WORST);
  end

endmodule

>>> design/fpa_alloc_ctrl.sv
// Scan sequencer: loads slots, walks the capacity memory and commits the pick.
module fpa_alloc_ctrl #(
  parameter int NUM_SLOTS = 16,
  parameter int SIZE_BITS = 16,
  parameter int SLOT_W    = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_opcode,
  input  logic [fpa_pkg::SLOT_FIELD_W-1:0] in_slot,
  input  logic [fpa_pkg::AMOUNT_W-1:0]     in_amount,
  input  logic [fpa_pkg::MODE_W-1:0]       fit_mode,
  output logic                             res_valid,
  input  logic                             res_ready,
  output fpa_pkg::res_t                    res
);
  import fpa_pkg::*;

  state_t               state, state_next;
  logic [SLOT_W-1:0]    idx, idx_next;
  logic [SLOT_W-1:0]    pick, pick_next;
  logic [SIZE_BITS-1:0] amt, amt_next;
  logic [SIZE_BITS-1:0] best, best_next;
  logic                 found, found_next;
  logic [NUM_SLOTS-1:0] loaded;

  logic                 mem_we;
  logic [SLOT_W-1:0]    mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic [SLOT_W-1:0]    mem_raddr;
  logic [SIZE_BITS-1:0] mem_rdata;
  logic [SIZE_BITS-1:0] diff;
  logic                 slot_ok;
  logic                 load_set;
  logic                 last;
  fit_dec_t             dec;

  fpa_cap_mem #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (SIZE_BITS),
    .AW    (SLOT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fpa_fit_unit #(
    .SIZE_BITS (SIZE_BITS)
  ) u_fit (
    .mode   (fit_mode),
    .cap    (mem_rdata),
    .amt    (amt),
    .best   (best),
    .loaded (loaded[idx]),
    .found  (found),
    .dec    (dec)
  );

  assign slot_ok  = int'(in_slot) < NUM_SLOTS;
  assign load_set = (state == ST_IDLE) && in_valid && (in_opcode == OP_LOAD) && slot_ok;
  assign last     = idx == SLOT_W'(NUM_SLOTS - 1);
  assign diff     = best - amt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      loaded <= '0;
    end else begin
      state <= state_next;
      if (load_set) begin
        loaded[SLOT_W'(in_slot)] <= 1'b1;
      end
    end
    idx   <= idx_next;
    pick  <= pick_next;
    amt   <= amt_next;
    best  <= best_next;
    found <= found_next;
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    pick_next  = pick;
    amt_next   = amt;
    best_next  = best;
    found_next = found;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = pick;
    mem_wdata  = diff;
    mem_raddr  = idx;
    res_valid  = 1'b0;
    res        = '0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = '0;
        if (in_valid) begin
          if (in_opcode == OP_LOAD) begin
            mem_we    = slot_ok;
            mem_waddr = SLOT_W'(in_slot);
            mem_wdata = SIZE_BITS'(in_amount);
          end else begin
            amt_next   = SIZE_BITS'(in_amount);
            found_next = 1'b0;
            pick_next  = '0;
            idx_next   = '0;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // read data is registered, so the address runs one slot ahead of idx
        mem_raddr = last ? idx : idx + SLOT_W'(1);
        if (dec.take) begin
          found_next = 1'b1;
          pick_next  = idx;
          best_next  = mem_rdata;
        end
        if (dec.stop || last) begin
          state_next = ST_WRITE;
        end else begin
          idx_next = idx + SLOT_W'(1);
        end
      end
      ST_WRITE: begin
        res_valid = 1'b1;
        if (found) begin
          res.granted     = 1'b1;
          res.chosen_slot = SLOT_FIELD_W'(pick);
          res.remaining   = AMOUNT_W'(diff);
        end
        if (res_ready) begin
          mem_we     = found;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> verif/fit_policy_partition_allocator_tb.sv
// Self-checking testbench for the fit-policy partition allocator.
`timescale 1ns / 1ps

module fit_policy_partition_allocator_tb;
  import fpa_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam int SIZE_BITS = 16;
  localparam int SETTLE = NUM_SLOTS + 8;
  localparam int LONG_STALL = 400;
  localparam int LIMIT = 300000;
  localparam int PHASE_ITEMS = 140;
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic                    opcode;
    logic [SLOT_FIELD_W-1:0] slot_index;
    logic [AMOUNT_W-1:0]     amount;
  } req_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpa_req_if req_ch ();
  fpa_rsp_if rsp_ch ();
  fpa_cfg_if cfg_ch ();

  fit_policy_partition_allocator #(
    .NUM_SLOTS(NUM_SLOTS),
    .SIZE_BITS(SIZE_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source),
    .cfg(cfg_ch.sink)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // partition table as the block should hold it
  logic [AMOUNT_W-1:0] slot_cap [NUM_SLOTS];
  logic                slot_loaded [NUM_SLOTS];
  logic [MODE_W-1:0]   fit_mode_q;

  req_item_t pending [$];
  res_t      grant_q [$];
  req_item_t cur_item;

  int   cycles = 0;
  int   errors = 0;
  int   items_in = 0;
  int   loads_in = 0;
  int   grants_seen = 0;
  int   refusals_seen = 0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  int   stall_cnt;

  task automatic report_miss(input string what, input int got, input int want);
    errors++;
    if (errors <= 50)
      $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  // scan in index order; ties keep the lower index
  function automatic res_t alloc_verdict(input logic [AMOUNT_W-1:0] want);
    res_t r;
    logic hit;
    logic stop;
    int   pick;
    r = '0;
    hit = 1'b0;
    stop = 1'b0;
    pick = 0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (!stop && slot_loaded[j] && slot_cap[j] >= want) begin
        if (!hit) begin
          hit = 1'b1;
          pick = j;
          if (fit_mode_q != MODE_BEST && fit_mode_q != MODE_WORST) stop = 1'b1;
        end else if (fit_mode_q == MODE_BEST && slot_cap[j] < slot_cap[pick]) begin
          pick = j;
        end else if (fit_mode_q == MODE_WORST && slot_cap[j] > slot_cap[pick]) begin
          pick = j;
        end
      end
    end
    if (hit) begin
      slot_cap[pick] = slot_cap[pick] - want;
      r.granted = 1'b1;
      r.chosen_slot = SLOT_FIELD_W'(pick);
      r.remaining = slot_cap[pick];
    end
    return r;
  endfunction

  function automatic void apply_request(input req_item_t it);
    if (it.opcode == OP_LOAD) begin
      if (int'(it.slot_index) < NUM_SLOTS) begin
        slot_cap[it.slot_index] = it.amount;
        slot_loaded[it.slot_index] = 1'b1;
      end
      loads_in++;
    end else begin
      grant_q.push_back(alloc_verdict(it.amount));
    end
  endfunction

  always @(posedge clk) begin : source_side
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        apply_request(cur_item);
        items_in++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
          cur_item = pending.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.opcode <= cur_item.opcode;
          req_ch.slot_index <= cur_item.slot_index;
          req_ch.amount <= cur_item.amount;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (rst) stall_cnt <= 0;
    else if (hold_req) stall_cnt <= LONG_STALL;
    else if (stall_cnt != 0) stall_cnt <= stall_cnt - 1;
  end

  always @(posedge clk) begin : sink_side
    res_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (grant_q.size() == 0) begin
          report_miss("result with no request pending, slot", rsp_ch.chosen_slot, 0);
        end else begin
          want = grant_q.pop_front();
          if (rsp_ch.granted !== want.granted)
            report_miss("granted", rsp_ch.granted, want.granted);
          if (rsp_ch.chosen_slot !== want.chosen_slot)
            report_miss("chosen_slot", rsp_ch.chosen_slot, want.chosen_slot);
          if (rsp_ch.remaining !== want.remaining)
            report_miss("remaining", rsp_ch.remaining, want.remaining);
          if (want.granted) grants_seen++;
          else refusals_seen++;
        end
      end
      rsp_ch.ready <= (stall_cnt == 0) && (calm || $urandom_range(0, 99) >= 32);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, grant_q.size());
      $display("fit_policy_partition_allocator verification failed");
      $finish;
    end
  end

  task automatic push_item(input logic op, input int slot, input int amt);
    req_item_t it;
    it.opcode = op;
    it.slot_index = SLOT_FIELD_W'(slot);
    it.amount = AMOUNT_W'(amt);
    pending.push_back(it);
  endtask

  // every item sent and answered, plus time for a trailing load to finish
  task automatic drain();
    while (pending.size() != 0 || req_ch.valid || grant_q.size() != 0 || stall_cnt != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(input logic [MODE_W-1:0] m);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.fit_mode <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    fit_mode_q = m;
  endtask

  // sizes mostly small so loads and requests meet; extremes now and then
  function automatic int pick_amount(input bit for_load);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      2, 3: return $urandom_range(0, 65535);
      default: return for_load ? $urandom_range(0, 4000) : $urandom_range(0, 1500);
    endcase
  endfunction

  task automatic push_random(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 40)
        push_item(OP_LOAD, $urandom_range(0, NUM_SLOTS - 1), pick_amount(1'b1));
      else
        push_item(OP_ALLOC, $urandom_range(0, 15), pick_amount(1'b0));
    end
  endtask

  initial begin : stimulus
    int base;
    logic [MODE_W-1:0] m;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_LOAD;
    req_ch.slot_index = '0;
    req_ch.amount = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.fit_mode = MODE_FIRST;
    fit_mode_q = MODE_FIRST;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      slot_cap[j] = '0;
      slot_loaded[j] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty table refuses even a zero request; zero request fits a zero capacity
    push_item(OP_ALLOC, 5, 0);
    push_item(OP_ALLOC, 0, 65535);
    push_item(OP_LOAD, 15, 0);
    push_item(OP_ALLOC, 0, 0);
    push_item(OP_LOAD, 0, 65535);
    push_item(OP_LOAD, 7, 100);
    push_item(OP_LOAD, 3, 100);
    push_item(OP_ALLOC, 15, 50);
    drain();
    set_mode(MODE_BEST);
    push_item(OP_ALLOC, 0, 60);
    push_item(OP_ALLOC, 0, 100);
    push_item(OP_ALLOC, 0, 65535);
    push_item(OP_ALLOC, 0, 0);
    drain();
    set_mode(MODE_WORST);
    push_item(OP_ALLOC, 0, 1);
    push_item(OP_LOAD, 9, 65535);
    push_item(OP_ALLOC, 0, 65535);
    push_item(OP_ALLOC, 0, 0);
    drain();
    // unused code acts as first fit
    set_mode(MODE_SPARE);
    push_item(OP_ALLOC, 0, 30);
    push_item(OP_LOAD, 15, 5);
    push_item(OP_ALLOC, 0, 5);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: m = MODE_WORST;
        1: m = MODE_BEST;
        2: m = MODE_FIRST;
        default: m = MODE_SPARE;
      endcase
      set_mode(m);
      calm <= (p == 2);
      base = items_in;
      push_random(PHASE_ITEMS);
      if (p == 5) begin
        while (items_in < base + 10) @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      drain();
      calm <= 1'b0;
    end

    $display("covered %0d items (%0d loads) over first, best, worst and spare policy codes",
             items_in, loads_in);
    $display("allocations: %0d granted, %0d refused", grants_seen, refusals_seen);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("fit_policy_partition_allocator verification clean");
    end else begin
      $display("fit_policy_partition_allocator verification failed");
    end
    $finish;
  end

endmodule
